// ===== rtl/core/cell_reference_parser_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CELL_REFERENCE_PARSER_TOP_ASSERT_SVH
`define CELL_REFERENCE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crp_pkg.sv =====
`default_nettype none

package crp_pkg;

    localparam int MAX_NAME_LEN = 16;

    localparam int CHAR_W      = 8;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 15;
    localparam int ROW_ACC_W   = 17;
    localparam int COUNT_W     = 4;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    // bijective base 26 column and decimal row
    localparam int COL_RADIX   = 26;
    localparam int ROW_RADIX   = 10;
    localparam int COL_PROD_W  = 20;
    localparam int ROW_PROD_W  = 20;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9   = 8'h39;

    // saturation points, one past the largest legal accumulator value
    localparam logic [COL_W-1:0]     COL_SAT = 15'd18279;
    localparam logic [ROW_ACC_W-1:0] ROW_SAT = 17'd65536;

    localparam logic [COUNT_W-1:0] LETTER_FAIL = COUNT_W'(MAX_NAME_LEN - 1);

    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = 16'd999;
    localparam logic [COL_W-1:0] COL_LIMIT_RST = 15'd18278;

    // register index, taken from paddr word bit
    typedef enum logic
    {
        REG_ROW_LIMIT = 1'b0,
        REG_COL_LIMIT = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/crp_if.sv =====
`default_nettype none

interface crp_char_if;
    logic                             valid;
    logic                             ready;
    logic [crp_pkg::CHAR_W-1:0]       char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface crp_result_if;
    logic                             valid;
    logic                             ready;
    logic                             valid_res;
    logic [crp_pkg::ROW_W-1:0]        row_index;
    logic [crp_pkg::COL_W-1:0]        col_pos;

    modport source (output valid, output valid_res, output row_index, output col_pos,
                    input ready);
    modport sink   (input valid, input valid_res, input row_index, input col_pos,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cell_reference_parser_top.sv =====
// Channel    Dir  Payload                               Transaction
// ---------  ---  ------------------------------------  -------------------------
// char_in    in   char_code[7:0]                        valid & ready
// res_out    out  valid_res, row_index[15:0],           valid & ready
//                 col_pos[14:0]
// apb        in   row_limit @0x0, col_limit @0x4        psel & penable & pwrite
//
// One character per cycle. The parse state updates at the accepting edge; a
// zero byte loads the result register, which shows the result the next cycle.
// char_in.ready drops only while the result register is full and not taken.
// Reset: state cleared, row_limit 999, col_limit 18278; no clearing pass.
`default_nettype none

module cell_reference_parser_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    crp_char_if.sink                           char_in,
    crp_result_if.source                       res_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [crp_pkg::DATA_W-1:0]    pwdata,
    output logic      [crp_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    typedef enum logic [1:0]
    {
        PH_LETTERS = 2'd0,
        PH_DIGITS  = 2'd1
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [crp_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [crp_pkg::COL_W-1:0]           col_acc_reg, col_acc_next;
    logic [crp_pkg::ROW_ACC_W-1:0]       row_acc_reg, row_acc_next;
    logic                                failed_reg, failed_next;

    logic [crp_pkg::ROW_W-1:0]           row_limit_reg, row_limit_next;
    logic [crp_pkg::COL_W-1:0]           col_limit_reg, col_limit_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_flag_reg, out_flag_next;
    logic [crp_pkg::ROW_W-1:0]           out_row_reg, out_row_next;
    logic [crp_pkg::COL_W-1:0]           out_col_reg, out_col_next;

    logic                                in_accept;
    logic                                is_upper;
    logic                                is_digit;
    logic                                ref_ok;
    logic                                cfg_write;
    crp_pkg::reg_idx_t                   cfg_idx;
    logic [crp_pkg::COL_PROD_W-1:0]      col_prod;
    logic [crp_pkg::ROW_PROD_W-1:0]      row_prod;
    logic [crp_pkg::COUNT_W-1:0]         count_inc;
    logic [crp_pkg::ROW_W-1:0]           row_zb;
    logic [crp_pkg::COL_W-1:0]           col_zb;

    assign char_in.ready = !out_valid_reg || res_out.ready;
    assign in_accept     = char_in.valid && char_in.ready;

    assign res_out.valid     = out_valid_reg;
    assign res_out.valid_res = out_flag_reg;
    assign res_out.row_index = out_row_reg;
    assign res_out.col_pos   = out_col_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = crp_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            crp_pkg::REG_ROW_LIMIT: prdata = crp_pkg::DATA_W'(row_limit_reg);
            crp_pkg::REG_COL_LIMIT: prdata = crp_pkg::DATA_W'(col_limit_reg);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        row_limit_next = row_limit_reg;
        col_limit_next = col_limit_reg;
        if (cfg_write)
        begin
            unique case (cfg_idx)
                crp_pkg::REG_ROW_LIMIT: row_limit_next = pwdata[crp_pkg::ROW_W-1:0];
                crp_pkg::REG_COL_LIMIT: col_limit_next = pwdata[crp_pkg::COL_W-1:0];
                default:                row_limit_next = row_limit_reg;
            endcase
        end
    end

    // character classes and accumulator steps
    assign is_upper  = (char_in.char_code >= crp_pkg::CHAR_A) &&
                       (char_in.char_code <= crp_pkg::CHAR_Z);
    assign is_digit  = (char_in.char_code >= crp_pkg::CHAR_0) &&
                       (char_in.char_code <= crp_pkg::CHAR_9);
    assign col_prod  = crp_pkg::COL_PROD_W'(col_acc_reg) *
                       crp_pkg::COL_PROD_W'(crp_pkg::COL_RADIX) +
                       crp_pkg::COL_PROD_W'(char_in.char_code - crp_pkg::CHAR_A + 8'd1);
    assign row_prod  = crp_pkg::ROW_PROD_W'(row_acc_reg) *
                       crp_pkg::ROW_PROD_W'(crp_pkg::ROW_RADIX) +
                       crp_pkg::ROW_PROD_W'(char_in.char_code - crp_pkg::CHAR_0);
    assign count_inc = count_reg + 1'b1;

    // end-of-reference check
    assign row_zb = row_acc_reg[crp_pkg::ROW_W-1:0] - 1'b1;
    assign col_zb = col_acc_reg - 1'b1;
    assign ref_ok = !failed_reg && (phase_reg == PH_DIGITS) &&
                    (row_acc_reg != '0) && (row_acc_reg < crp_pkg::ROW_SAT) &&
                    (row_acc_reg <= crp_pkg::ROW_ACC_W'(row_limit_reg)) &&
                    (col_acc_reg != '0) && (col_acc_reg < crp_pkg::COL_SAT) &&
                    (col_zb < col_limit_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        col_acc_next   = col_acc_reg;
        row_acc_next   = row_acc_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !res_out.ready;
        out_flag_next  = out_flag_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        if (in_accept)
        begin
            if (char_in.char_code == crp_pkg::CHAR_NUL)
            begin
                out_valid_next = 1'b1;
                out_flag_next  = ref_ok;
                out_row_next   = ref_ok ? row_zb : '0;
                out_col_next   = ref_ok ? col_zb : '0;
                phase_next     = PH_LETTERS;
                count_next     = '0;
                col_acc_next   = '0;
                row_acc_next   = '0;
                failed_next    = 1'b0;
            end
            else if (!failed_reg)
            begin
                unique case (phase_reg)
                    PH_LETTERS:
                    begin
                        if (is_upper)
                        begin
                            col_acc_next = (col_prod >= crp_pkg::COL_PROD_W'(crp_pkg::COL_SAT))
                                         ? crp_pkg::COL_SAT
                                         : col_prod[crp_pkg::COL_W-1:0];
                            count_next   = count_inc;
                            if (count_inc >= crp_pkg::LETTER_FAIL)
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        else if (is_digit && (count_reg != '0))
                        begin
                            phase_next   = PH_DIGITS;
                            row_acc_next = crp_pkg::ROW_ACC_W'(char_in.char_code -
                                                               crp_pkg::CHAR_0);
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            row_acc_next = (row_prod >= crp_pkg::ROW_PROD_W'(crp_pkg::ROW_SAT))
                                         ? crp_pkg::ROW_SAT
                                         : row_prod[crp_pkg::ROW_ACC_W-1:0];
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LETTERS;
            count_reg     <= '0;
            col_acc_reg   <= '0;
            row_acc_reg   <= '0;
            failed_reg    <= 1'b0;
            row_limit_reg <= crp_pkg::ROW_LIMIT_RST;
            col_limit_reg <= crp_pkg::COL_LIMIT_RST;
            out_valid_reg <= 1'b0;
            out_flag_reg  <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            col_acc_reg   <= col_acc_next;
            row_acc_reg   <= row_acc_next;
            failed_reg    <= failed_next;
            row_limit_reg <= row_limit_next;
            col_limit_reg <= col_limit_next;
            out_valid_reg <= out_valid_next;
            out_flag_reg  <= out_flag_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crp_checker.sv =====
`default_nettype none

`include "cell_reference_parser_top_assert.svh"

module crp_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [crp_pkg::CHAR_W-1:0]    char_code,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          valid_res,
    input wire logic [crp_pkg::ROW_W-1:0]     row_index,
    input wire logic [crp_pkg::COL_W-1:0]     col_pos
);

    logic                                              in_xact;
    logic                                              nul_in;
    logic                                              other_in;
    logic                                              out_stall;
    logic                                              idx_zero;
    logic [crp_pkg::ROW_W+crp_pkg::COL_W:0]            out_payload;

    assign in_xact     = in_valid && in_ready;
    assign nul_in      = in_xact && (char_code == crp_pkg::CHAR_NUL);
    assign other_in    = in_xact && (char_code != crp_pkg::CHAR_NUL);
    assign out_stall   = out_valid && !out_ready;
    assign idx_zero    = (row_index == '0) && (col_pos == '0);
    assign out_payload = {valid_res, row_index, col_pos};

    // a stalled result keeps its payload
    `CRP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "stalled result changed")

    // a zero byte always yields a result next cycle
    `CRP_ASSERT_NEXT(a_nul_result, nul_in, out_valid, "zero byte gave no result")

    // any other character yields none
    `CRP_ASSERT_NEXT(a_no_spurious, other_in, !out_valid, "result without zero byte")

    // an invalid reference carries zero indices
    `CRP_ASSERT_NOW(a_invalid_zero, out_valid && !valid_res, idx_zero, "invalid result has index")

    // input side never stalls while the result register is empty
    `CRP_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind cell_reference_parser_top crp_checker u_crp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (char_in.valid),
    .in_ready  (char_in.ready),
    .char_code (char_in.char_code),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .valid_res (res_out.valid_res),
    .row_index (res_out.row_index),
    .col_pos   (res_out.col_pos)
);

`default_nettype wire
